### hw/rtl/nearest_point_search_defines.svh
// Assertion macros for the nearest point search block.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nearest_point_search: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nearest_point_search: next-cycle check failed");

`endif

### hw/rtl/nps_pkg.sv
// Shared widths, codes and defaults for the nearest point search block.
// Used by nps_isqrt and nearest_point_search; depends on nothing.
package nps_pkg;

	// Default geometry.
	localparam int LIST_COUNT_DEF      = 4;
	localparam int POINTS_PER_LIST_DEF = 512;

	// Field widths.
	localparam int OP_W     = 2;
	localparam int SEL_W    = 2;
	localparam int COORD_W  = 24;
	localparam int STATUS_W = 2;
	localparam int NLIST_W  = 2;
	localparam int NINDEX_W = 9;
	localparam int DIST_W   = 25;

	// Arithmetic widths: a coordinate difference, a squared distance, its root.
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int ROOT_W = SQ_W / 2;

	// Stream layout.
	localparam int PT_W          = 3 * COORD_W;
	localparam int IN_TDATA_W    = ((PT_W + 7) / 8) * 8;
	localparam int IN_TUSER_W    = OP_W + SEL_W;
	localparam int OUT_FIELDS_W  = NLIST_W + NINDEX_W + DIST_W;
	localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W   = STATUS_W;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_ALL    = 2'd2;
	localparam logic [OP_W-1:0] OP_ONE    = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

endpackage

### hw/rtl/nearest_point_search.sv
// Nearest point search: point lists in one synchronous memory, scanned per query.
// Depends on nps_pkg, nps_isqrt and nearest_point_search_defines.svh.
//
//   channel   direction  tdata                              tuser
//   s_*       in         coord_x, coord_y, coord_z          op, list_select
//   m_*       out        nearest_list, nearest_index, dist  status
//
// A clear or an append goes from its transfer to the done state, then to the result register.
// A query makes one memory read per stored point in each list it looks at, passes
// each point through a four-stage distance pipeline and then runs the 25-step root.
// The single read port of the point memory sets the scan rate of one point a cycle.
// Of the stored data, reset zeroes the list counts only; the point memory is not
// cleared, since no entry at or beyond its list's count is ever read.
// Input is taken only while no item is in work. A result that is not taken stalls
// the next item at the point where its own result is ready.
`include "nearest_point_search_defines.svh"

module nearest_point_search #(
	parameter int LIST_COUNT      = nps_pkg::LIST_COUNT_DEF,
	parameter int POINTS_PER_LIST = nps_pkg::POINTS_PER_LIST_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// coord_x [23:0], coord_y [47:24], coord_z [71:48]
	input  logic [nps_pkg::IN_TDATA_W-1:0]    s_tdata,
	// op [1:0], list_select [3:2]
	input  logic [nps_pkg::IN_TUSER_W-1:0]    s_tuser,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// nearest_list [1:0], nearest_index [10:2], distance [35:11], zero [39:36]
	output logic [nps_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// status [1:0]
	output logic [nps_pkg::OUT_TUSER_W-1:0]   m_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready
);
	import nps_pkg::*;

	// Storage geometry. A point lives at address {list, position}.
	localparam int LW        = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam int PW        = $clog2(POINTS_PER_LIST);
	localparam int CW        = $clog2(POINTS_PER_LIST + 1);
	localparam int AW        = LW + PW;
	localparam int MEM_DEPTH = LIST_COUNT * (2 ** PW);

	// Controller states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_SQRT  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	// Input fields.
	logic [OP_W-1:0]          in_op;
	logic [SEL_W-1:0]         in_sel;
	logic [COORD_W-1:0]       in_x;
	logic [COORD_W-1:0]       in_y;
	logic [COORD_W-1:0]       in_z;

	logic [2:0]               state_q;
	logic [CW-1:0]            list_counts_q [LIST_COUNT];
	logic [LW-1:0]            cur_list_q;
	logic [CW-1:0]            idx_q;
	logic                     one_list_q;

	logic [COORD_W-1:0]       qx_q;
	logic [COORD_W-1:0]       qy_q;
	logic [COORD_W-1:0]       qz_q;

	logic                     found_q;
	logic [LW-1:0]            best_list_q;
	logic [PW-1:0]            best_idx_q;
	logic [SQ_W-1:0]          best_sq_q;

	logic [STATUS_W-1:0]      pend_status_q;
	logic [NLIST_W-1:0]       pend_list_q;
	logic [NINDEX_W-1:0]      pend_index_q;
	logic [DIST_W-1:0]        pend_dist_q;

	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic [OUT_TUSER_W-1:0]   m_tuser_q;

	// Point memory and the scan pipeline.
	logic [PT_W-1:0]          mem [MEM_DEPTH];
	logic [PT_W-1:0]          rdata_s1;
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [LW-1:0]            list_s1, list_s2, list_s3, list_s4;
	logic [PW-1:0]            idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [SQ_W-1:0]   prod_x, prod_y, prod_z;
	logic [SQ_W-1:0]          sqx_s3, sqy_s3, sqz_s3;
	logic [SQ_W-1:0]          sum_s4;

	logic                     accept;
	logic                     sel_ok;
	logic [LW-1:0]            sel_idx;
	logic [LW-1:0]            cnt_idx;
	logic [CW-1:0]            count_rd;
	logic                     list_full;
	logic                     mem_we;
	logic [AW-1:0]            waddr;
	logic                     rd_en;
	logic [AW-1:0]            raddr;
	logic                     pipe_busy;
	logic                     better;
	logic                     out_free;

	logic                     sq_start;
	logic                     sq_done;
	logic [ROOT_W-1:0]        sq_root;

	assign in_op  = s_tuser[OP_W-1:0];
	assign in_sel = s_tuser[OP_W +: SEL_W];
	assign in_x   = s_tdata[0 +: COORD_W];
	assign in_y   = s_tdata[COORD_W +: COORD_W];
	assign in_z   = s_tdata[2*COORD_W +: COORD_W];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// A list number at or past LIST_COUNT names no list.
	assign sel_ok  = (int'(in_sel) < LIST_COUNT);
	assign sel_idx = LW'(in_sel);

	// The count table has one read port, shared by the decoder and the scan.
	assign cnt_idx   = (state_q == S_SCAN) ? cur_list_q : sel_idx;
	assign count_rd  = list_counts_q[cnt_idx];
	assign list_full = (count_rd == CW'(POINTS_PER_LIST));

	assign mem_we = accept && (in_op == OP_APPEND) && sel_ok && !list_full;
	assign waddr  = {sel_idx, count_rd[PW-1:0]};

	assign rd_en = (state_q == S_SCAN) && (idx_q < count_rd);
	assign raddr = {cur_list_q, idx_q[PW-1:0]};

	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign better    = v_s4 && (!found_q || (sum_s4 < best_sq_q));
	assign sq_start  = (state_q == S_DRAIN) && !pipe_busy && found_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// Full-width squares; each operand carries only 25 significant bits.
	assign prod_x = SQ_W'(dx_s2) * SQ_W'(dx_s2);
	assign prod_y = SQ_W'(dy_s2) * SQ_W'(dy_s2);
	assign prod_z = SQ_W'(dz_s2) * SQ_W'(dz_s2);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= {in_z, in_y, in_x};
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Distance pipeline: read, differences, squares, sum.
	always_ff @(posedge clk) begin
		list_s1 <= cur_list_q;
		idx_s1  <= idx_q[PW-1:0];

		dx_s2   <= $signed({rdata_s1[COORD_W-1], rdata_s1[0 +: COORD_W]})
		         - $signed({qx_q[COORD_W-1], qx_q});
		dy_s2   <= $signed({rdata_s1[2*COORD_W-1], rdata_s1[COORD_W +: COORD_W]})
		         - $signed({qy_q[COORD_W-1], qy_q});
		dz_s2   <= $signed({rdata_s1[3*COORD_W-1], rdata_s1[2*COORD_W +: COORD_W]})
		         - $signed({qz_q[COORD_W-1], qz_q});
		list_s2 <= list_s1;
		idx_s2  <= idx_s1;

		sqx_s3  <= unsigned'(prod_x);
		sqy_s3  <= unsigned'(prod_y);
		sqz_s3  <= unsigned'(prod_z);
		list_s3 <= list_s2;
		idx_s3  <= idx_s2;

		// Three squares of 25-bit differences stay below 2**50.
		sum_s4  <= sqx_s3 + sqy_s3 + sqz_s3;
		list_s4 <= list_s3;
		idx_s4  <= idx_s3;

		// Only a strictly closer point replaces the best, so earlier ones win ties.
		if (better) begin
			best_list_q <= list_s4;
			best_idx_q  <= idx_s4;
			best_sq_q   <= sum_s4;
		end

		if (accept) begin
			qx_q <= in_x;
			qy_q <= in_y;
			qz_q <= in_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Controller and list counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_list_q <= '0;
			idx_q      <= '0;
			one_list_q <= 1'b0;
			found_q    <= 1'b0;
			for (int i = 0; i < LIST_COUNT; i++) begin
				list_counts_q[i] <= '0;
			end
		end else begin
			if (better) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_CLEAR: begin
								if (sel_ok) begin
									list_counts_q[sel_idx] <= '0;
								end
								state_q <= S_DONE;
							end
							OP_APPEND: begin
								if (mem_we) begin
									list_counts_q[sel_idx] <= count_rd + CW'(1);
								end
								state_q <= S_DONE;
							end
							OP_ALL: begin
								cur_list_q <= '0;
								idx_q      <= '0;
								one_list_q <= 1'b0;
								found_q    <= 1'b0;
								state_q    <= S_SCAN;
							end
							OP_ONE: begin
								cur_list_q <= sel_idx;
								idx_q      <= '0;
								one_list_q <= 1'b1;
								found_q    <= 1'b0;
								state_q    <= sel_ok ? S_SCAN : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end else if (one_list_q || cur_list_q == LW'(LIST_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cur_list_q <= cur_list_q + LW'(1);
						idx_q      <= '0;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= found_q ? S_SQRT : S_DONE;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result waiting for the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_list_q  <= '0;
			pend_index_q <= '0;
			pend_dist_q  <= '0;
			case (in_op)
				OP_APPEND: pend_status_q <= mem_we ? ST_OK : ST_DROPPED;
				OP_ONE:    pend_status_q <= sel_ok ? ST_OK : ST_NOTFOUND;
				default:   pend_status_q <= ST_OK;
			endcase
		end else if (state_q == S_DRAIN && !pipe_busy && !found_q) begin
			pend_status_q <= ST_NOTFOUND;
		end else if (state_q == S_SQRT && sq_done) begin
			pend_status_q <= ST_OK;
			pend_list_q   <= NLIST_W'(best_list_q);
			pend_index_q  <= NINDEX_W'(best_idx_q);
			pend_dist_q   <= DIST_W'(sq_root);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), pend_dist_q,
			              pend_index_q, pend_list_q};
			m_tuser_q <= pend_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	nps_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (best_sq_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Scan tags in flight only while a query scans or drains.
	`NPS_ASSERT_NOW(a_pipe_in_query, clk, arst_n, v_s4, (state_q == S_SCAN || state_q == S_DRAIN))
	// The root finishes only while the controller waits for it.
	`NPS_ASSERT_NOW(a_root_when_waiting, clk, arst_n, sq_done, (state_q == S_SQRT))
	// A root is computed only after at least one point was found.
	`NPS_ASSERT_NOW(a_root_has_point, clk, arst_n, (state_q == S_SQRT), found_q)
	// Leaving the drain with nothing in flight goes to the root or the result.
	`NPS_ASSERT_NEXT(a_drain_exit, clk, arst_n, (state_q == S_DRAIN && !pipe_busy),
		(state_q == S_SQRT || state_q == S_DONE))

endmodule

### hw/rtl/nps_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nps_pkg for the radicand and root widths.
module nps_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nps_pkg::SQ_W-1:0]    radicand,
	output logic                        done,
	output logic [nps_pkg::ROOT_W-1:0]  root
);
	import nps_pkg::*;

	localparam int STEPS  = ROOT_W;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int CUR_W  = ROOT_W + 3;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [SQ_W-1:0]     rad_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;

	logic [CUR_W-1:0]    cur;
	logic [CUR_W-1:0]    trial;
	logic [CUR_W-1:0]    diff;
	logic                take;

	// Bring down the next two radicand bits and try the next root bit.
	assign cur   = {rem_q, rad_q[SQ_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take  = (cur >= trial);
	assign diff  = cur - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(STEPS);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= take ? diff[ROOT_W:0] : cur[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### verif/nearest_point_search_test.sv
// Self-checking testbench for nearest_point_search: directed, full-list, backpressure
// and random traffic, each answer checked against a behavioral search over point lists.
// Depends on nps_pkg and the nearest_point_search RTL.
module nearest_point_search_test;
	import nps_pkg::*;

	localparam int NUM_LISTS    = LIST_COUNT_DEF;
	localparam int LIST_DEPTH   = POINTS_PER_LIST_DEF;
	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 4;
	// A full scan of every list plus a receiver hold-off fits many times over in the
	// watchdog limit, which ends the run only after that long without a single transfer.
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [SEL_W-1:0] FULL_LIST = SEL_W'(NUM_LISTS - 1);

	typedef logic signed [COORD_W-1:0] coord_t;

	// Packed so that x lands in the lowest bits of s_tdata, then y, then z.
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NLIST_W-1:0]  list_no;
		logic [NINDEX_W-1:0] index;
		logic [DIST_W-1:0]   distance;
	} answer_t;

	// Stall patterns of the result receiver.
	typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_pattern_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [IN_TUSER_W-1:0]  s_tuser  = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;

	// Shadow copy of the block's lists, kept in step with every accepted transfer.
	point_t      shadow_points[NUM_LISTS][LIST_DEPTH];
	int unsigned shadow_fill[NUM_LISTS];

	// Answers predicted for accepted items, oldest first.
	answer_t pending_answers[$];

	int mismatches  = 0;
	int idle_cycles = 0;
	int burst_left  = 0;

	// The test side asks for a long receiver hold-off through these two variables.
	int rx_hold_request = 0;
	bit rx_holding      = 1'b0;

	nearest_point_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Exact squared Euclidean distance; below 2**50, so 64 bits hold it easily.
	function automatic longint unsigned squared_distance(point_t a, point_t b);
		longint dx, dy, dz;
		dx = a.x - b.x;
		dy = a.y - b.y;
		dz = a.z - b.z;
		return longint'(dx * dx + dy * dy + dz * dz);
	endfunction

	// Floor square root, built one result bit at a time from the top down.
	function automatic logic [DIST_W-1:0] floor_root(longint unsigned value);
		longint unsigned root, trial;
		root = 0;
		for (int b = DIST_W; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= value)
				root = trial;
		end
		return root[DIST_W-1:0];
	endfunction

	// Applies one item to the shadow lists and returns the answer it must produce.
	// Only a strictly smaller distance replaces the best so far, so scanning lists
	// and positions in ascending order gives the lowest list, then lowest position.
	function automatic answer_t compute_answer(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel,
			point_t p);
		answer_t ans;
		bit found;
		longint unsigned best, d;
		int first_list, last_list;
		ans = '0;
		ans.status = ST_OK;
		found = 1'b0;
		best = 0;
		case (op)
		OP_CLEAR: begin
			shadow_fill[sel] = 0;
		end
		OP_APPEND: begin
			if (shadow_fill[sel] < LIST_DEPTH) begin
				shadow_points[sel][shadow_fill[sel]] = p;
				shadow_fill[sel]++;
			end else begin
				ans.status = ST_DROPPED;
			end
		end
		default: begin
			first_list = (op == OP_ALL) ? 0 : int'(sel);
			last_list  = (op == OP_ALL) ? NUM_LISTS - 1 : int'(sel);
			for (int l = first_list; l <= last_list; l++) begin
				for (int i = 0; i < shadow_fill[l]; i++) begin
					d = squared_distance(shadow_points[l][i], p);
					if (!found || d < best) begin
						found = 1'b1;
						best = d;
						ans.list_no = NLIST_W'(l);
						ans.index = NINDEX_W'(i);
					end
				end
			end
			if (found)
				ans.distance = floor_root(best);
			else
				ans.status = ST_NOTFOUND;
		end
		endcase
		return ans;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic point_t make_point(coord_t x, coord_t y, coord_t z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	// Mostly small values near the origin so that close calls and ties are common,
	// with full-range values and the two extremes mixed in.
	function automatic coord_t pick_coord();
		case ($urandom_range(0, 5))
		0: begin
			return coord_t'($urandom);
		end
		1: begin
			return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		end
		default: begin
			return coord_t'(int'($urandom_range(0, 48)) - 24);
		end
		endcase
	endfunction

	// Either a fresh point, or a stored one (possibly nudged by one unit) so that
	// exact hits and near hits against the lists are frequent.
	function automatic point_t pick_point();
		point_t p;
		int l;
		l = $urandom_range(0, NUM_LISTS - 1);
		if ($urandom_range(0, 3) == 0 && shadow_fill[l] != 0) begin
			p = shadow_points[l][$urandom_range(0, shadow_fill[l] - 1)];
			if ($urandom_range(0, 1))
				p.y = p.y + coord_t'(int'($urandom_range(0, 2)) - 1);
			return p;
		end
		return make_point(pick_coord(), pick_coord(), pick_coord());
	endfunction

	// Offers one item and returns once it is transferred. The sender works in
	// bursts; valid only drops between bursts, never in the middle of one.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
			input point_t p);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		s_tuser  <= {sel, op};
		do @(posedge clk); while (!s_tready);
		pending_answers = {pending_answers, compute_answer(op, sel, p)};
		burst_left--;
		if (burst_left == 0)
			s_tvalid <= 1'b0;
	endtask

	// Ends the current burst early; needed before anything that lets time pass
	// between items, so that a stale item is never offered twice.
	task automatic pause_sender();
		if (burst_left != 0) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty searches, the largest possible distance, ties within and across lists,
	// a cleared list taking no part, and clears of empty lists.
	task automatic test_directed_cases();
		point_t origin, low_corner, high_corner;
		origin      = make_point(0, 0, 0);
		low_corner  = make_point(COORD_MIN, COORD_MIN, COORD_MIN);
		high_corner = make_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_item(OP_ALL, 0, origin);
		send_item(OP_ONE, 2, origin);
		send_item(OP_CLEAR, 1, origin);
		send_item(OP_APPEND, 0, low_corner);
		send_item(OP_ALL, 3, high_corner);
		send_item(OP_ONE, 1, origin);
		send_item(OP_APPEND, 1, high_corner);
		send_item(OP_APPEND, 2, origin);
		send_item(OP_APPEND, 2, origin);
		send_item(OP_APPEND, 3, origin);
		send_item(OP_ALL, 1, make_point(1, -1, 1));
		send_item(OP_ONE, 3, make_point(0, 0, 5));
		send_item(OP_APPEND, 3, make_point(3, 4, 0));
		send_item(OP_ONE, 3, make_point(3, 4, 1));
		send_item(OP_ALL, 0, high_corner);
		send_item(OP_ONE, 0, high_corner);
		send_item(OP_CLEAR, 2, origin);
		send_item(OP_ONE, 2, origin);
		send_item(OP_ALL, 2, make_point(2, 2, 2));
		for (int l = 0; l < NUM_LISTS; l++)
			send_item(OP_CLEAR, SEL_W'(l), high_corner);
		send_item(OP_ALL, 0, origin);
		pause_sender();
	endtask

	// Fills one list to capacity, checks that a further append is dropped, that the
	// last position is found, and that the list empties again on a clear.
	task automatic test_full_list();
		point_t last_point;
		for (int i = 0; i < LIST_DEPTH; i++)
			send_item(OP_APPEND, FULL_LIST, make_point(pick_coord(), pick_coord(),
				coord_t'($urandom)));
		send_item(OP_APPEND, FULL_LIST, make_point(1, 2, 3));
		last_point = shadow_points[FULL_LIST][LIST_DEPTH - 1];
		send_item(OP_ONE, FULL_LIST, last_point);
		send_item(OP_ALL, 0, pick_point());
		send_item(OP_CLEAR, FULL_LIST, last_point);
		send_item(OP_ONE, FULL_LIST, last_point);
		pause_sender();
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// block must hold its result and stall its input until the receiver returns.
	task automatic test_backpressure();
		logic [SEL_W-1:0] sel;
		rx_hold_request = HOLD_CYCLES;
		while (!rx_holding) @(posedge clk);
		for (int i = 0; i < 12; i++) begin
			sel = SEL_W'(i % NUM_LISTS);
			send_item((i % 3 == 2) ? OP_ALL : OP_APPEND, sel, pick_point());
		end
		pause_sender();
	endtask

	// Random mix of all operations; clears keep the lists short so queries stay quick.
	task automatic test_random_traffic();
		int kind;
		logic [SEL_W-1:0] sel;
		repeat (RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			sel = SEL_W'($urandom_range(0, NUM_LISTS - 1));
			if (kind < 8)
				send_item(OP_CLEAR, sel, pick_point());
			else if (kind < 50)
				send_item(OP_APPEND, sel, pick_point());
			else if (kind < 75)
				send_item(OP_ALL, sel, pick_point());
			else
				send_item(OP_ONE, sel, pick_point());
		end
		pause_sender();
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Every result transfer is matched against the oldest predicted answer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d data 0x%0h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("nearest_list", want.list_no, m_tdata[NLIST_W-1:0]);
				check_field("nearest_index", want.index,
					m_tdata[NLIST_W+NINDEX_W-1:NLIST_W]);
				check_field("distance", want.distance,
					m_tdata[OUT_FIELDS_W-1:NLIST_W+NINDEX_W]);
				check_field("padding", 0, m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
			end
		end
	end

	// Ends the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Result receiver: segments of random length, each with its own stall pattern,
	// and a long hold-off whenever the test side asks for one.
	initial begin : receiver
		int seg_len, held, tick;
		rx_pattern_t pattern;
		tick = 0;
		while (!arst_n) @(posedge clk);
		@(posedge clk);
		forever begin
			if (rx_hold_request > 0) begin
				held = rx_hold_request;
				rx_hold_request = 0;
				rx_holding = 1'b1;
				m_tready <= 1'b0;
				repeat (held) @(posedge clk);
				rx_holding = 1'b0;
			end
			seg_len = $urandom_range(4, 40);
			pattern = rx_pattern_t'($urandom_range(0, 3));
			repeat (seg_len) begin
				case (pattern)
				RX_STEADY:      m_tready <= 1'b1;
				RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE:      m_tready <= ($urandom_range(0, 3) == 0);
				RX_EVERY_THIRD: m_tready <= (tick % 3 == 0);
				default:        m_tready <= 1'b1;
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	// Reset once, run each test in turn, then let the last results drain.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_list();
		test_backpressure();
		test_random_traffic();
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
